// ===== src/fat12_cluster_chain_walker_assert.svh =====
// assertion macros for the cluster chain walker
// used by the top level; needs nothing else
`ifndef FAT12_CLUSTER_CHAIN_WALKER_ASSERT_SVH
`define FAT12_CLUSTER_CHAIN_WALKER_ASSERT_SVH

// property that must hold on every clock edge out of reset
`define FCW_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error(msg);

// condition that must be followed by a consequence in the next cycle
`define FCW_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/fcw_pkg.sv =====
// shared types and constants of the cluster chain walker
// no dependencies
`timescale 1ns / 1ps

package fcw_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_SECTOR    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SECTORS_PER_CLUSTER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DATA_START_SECTOR   = 2'd2;

	localparam logic [12:0] BPS_RESET = 13'd512;
	localparam logic [7:0]  SPC_RESET = 8'd1;
	localparam logic [15:0] DSS_RESET = 16'd33;

	// request codes
	localparam logic REQ_TABLE_WRITE = 1'b0;
	localparam logic REQ_WALK        = 1'b1;

	// chain markers
	localparam logic [11:0] CHAIN_END     = 12'hFF8;
	localparam logic [11:0] CLUSTER_FREE  = 12'h000;
	localparam logic [11:0] CLUSTER_RSVD  = 12'h001;
	localparam logic [19:0] COUNT_MAX     = 20'hFFFFF;

	typedef struct packed {
		logic        req_type;
		logic [12:0] table_index;
		logic [7:0]  table_byte;
		logic [11:0] start_cluster;
		logic [31:0] file_size;
	} req_t;

	typedef struct packed {
		logic [31:0] data_offset;
		logic [19:0] byte_count;
		logic [11:0] cluster_number;
		logic        last;
		logic        bad_cluster;
		logic        truncated;
	} res_t;

endpackage

// ===== src/fcw_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module fcw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/fat12_cluster_chain_walker.sv =====
// top level of the fat12 cluster chain walker
// depends on fcw_pkg, fcw_ram and fat12_cluster_chain_walker_assert.svh
`timescale 1ns / 1ps
`include "fat12_cluster_chain_walker_assert.svh"

// Usage
// A request word is taken on a rising edge with start high and busy low.
// A table write (req_type 0) stores one allocation table byte in that cycle;
// busy stays low, so writes can come every cycle while no walk is running.
// A walk (req_type 1) raises busy on the next cycle. Each cluster of the
// chain passes through an eval state, which addresses both table banks (even
// and odd bytes are split, so the 16-bit entry comes in one registered read),
// and a read state, which decodes the next cluster.
// A result word for a cluster appears once the following entry is known;
// each result is on result for one cycle with result_valid high and there
// is no backpressure.
// Configuration writes on cfg_we take effect at once and must come while
// busy is low. Reset returns the configuration to its defaults and stops any
// walk; table contents are undefined until written and need no clearing.
// TABLE_BYTES must be even.

module fat12_cluster_chain_walker #(
	parameter int TABLE_BYTES = 8192,
	parameter int MAX_CHAIN   = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  fcw_pkg::req_t                    req,
	output logic                             result_valid,
	output fcw_pkg::res_t                    result,
	input  logic                             cfg_we,
	input  logic [fcw_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fcw_pkg::CFG_DATA_W-1:0]   cfg_data
);

	import fcw_pkg::*;

	localparam int BANK_DEPTH = TABLE_BYTES / 2;
	localparam int AW         = $clog2(BANK_DEPTH);
	localparam int KW         = $clog2(MAX_CHAIN + 1);
	localparam logic [13:0] TB_LIM = 14'(TABLE_BYTES);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EVAL = 4'b0010,
		ST_READ = 4'b0100,
		ST_BAD  = 4'b1000
	} state_t;

	state_t state_q;

	logic [12:0] bps_q;
	logic [7:0]  spc_q;
	logic [15:0] dss_q;

	logic [20:0] clus_q;
	logic [28:0] base_q;
	logic [31:0] remain_q;
	logic [11:0] c_q;
	logic [KW-1:0] k_q;
	logic [12:0] off_q;
	logic [31:0] prod_s1;

	logic [31:0] pend_offs_q;
	logic [19:0] pend_cnt_q;
	logic [11:0] pend_cl_q;

	res_t result_q;
	logic result_valid_q;

	logic accept;
	logic wr_ok;
	logic [AW-1:0] even_raddr, odd_raddr;
	logic [7:0] even_rd, odd_rd;
	logic [12:0] off, off_p1;
	logic [7:0] lo_byte, hi_byte;
	logic [15:0] entry;
	logic [11:0] next_c;
	logic is_end;
	logic clus_lt;
	logic [20:0] cnt_full;
	logic [19:0] cnt_sat;
	logic [31:0] prod_full;

	assign accept = start && (state_q == ST_IDLE);
	assign busy = (state_q != ST_IDLE);

	// table write decode: out of range index is dropped
	assign wr_ok = accept && (req.req_type == REQ_TABLE_WRITE)
		&& ({1'b0, req.table_index} < TB_LIM);

	// byte position of the entry of the current cluster
	assign off    = {1'b0, c_q} + {2'b00, c_q[11:1]};
	assign off_p1 = off + 13'd1;
	assign odd_raddr  = off[AW:1];
	assign even_raddr = off_p1[AW:1];

	fcw_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_even (
		.clk  (clk),
		.we   (wr_ok && !req.table_index[0]),
		.waddr(req.table_index[AW:1]),
		.wdata(req.table_byte),
		.raddr(even_raddr),
		.rdata(even_rd)
	);

	fcw_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_odd (
		.clk  (clk),
		.we   (wr_ok && req.table_index[0]),
		.waddr(req.table_index[AW:1]),
		.wdata(req.table_byte),
		.raddr(odd_raddr),
		.rdata(odd_rd)
	);

	// entry assembly from the two banks, bytes past the table read as zero
	always_comb begin
		logic [13:0] pos_lo;
		logic [13:0] pos_hi;
		pos_lo = {1'b0, off_q};
		pos_hi = {1'b0, off_q} + 14'd1;
		if (!off_q[0]) begin
			lo_byte = even_rd;
			hi_byte = odd_rd;
		end else begin
			lo_byte = odd_rd;
			hi_byte = even_rd;
		end
		if (pos_lo >= TB_LIM) begin
			lo_byte = 8'h00;
		end
		if (pos_hi >= TB_LIM) begin
			hi_byte = 8'h00;
		end
		entry  = {hi_byte, lo_byte};
		next_c = c_q[0] ? entry[15:4] : entry[11:0];
	end

	// segment length and chain end tests
	assign is_end   = (c_q == CLUSTER_FREE) || (c_q >= CHAIN_END);
	assign clus_lt  = ({11'd0, clus_q} < remain_q);
	assign cnt_full = clus_lt ? clus_q : remain_q[20:0];
	assign cnt_sat  = cnt_full[20] ? COUNT_MAX : cnt_full[19:0];
	assign prod_full = 32'(clus_q) * 32'(c_q - 12'd2);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bps_q <= BPS_RESET;
			spc_q <= SPC_RESET;
			dss_q <= DSS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BYTES_PER_SECTOR:    bps_q <= cfg_data[12:0];
				CFG_SECTORS_PER_CLUSTER: spc_q <= cfg_data[7:0];
				CFG_DATA_START_SECTOR:   dss_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// walk sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			k_q            <= '0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && (req.req_type == REQ_WALK)) begin
						k_q     <= '0;
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (is_end) begin
						result_valid_q <= 1'b1;
						state_q        <= ST_IDLE;
					end else if (k_q >= KW'(MAX_CHAIN)) begin
						result_valid_q <= 1'b1;
						state_q        <= ST_IDLE;
					end else if (c_q == CLUSTER_RSVD) begin
						result_valid_q <= (k_q != '0);
						state_q        <= ST_BAD;
					end else begin
						result_valid_q <= (k_q != '0);
						k_q            <= k_q + KW'(1);
						state_q        <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_EVAL;
				end
				ST_BAD: begin
					result_valid_q <= 1'b1;
					state_q        <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// walk datapath and result word
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				c_q      <= req.start_cluster;
				remain_q <= req.file_size;
				clus_q   <= 21'(bps_q) * 21'(spc_q);
				base_q   <= 29'(dss_q) * 29'(bps_q);
			end
			ST_EVAL: begin
				if (is_end) begin
					if (k_q == '0) begin
						result_q <= '{data_offset: 32'd0, byte_count: 20'd0,
							cluster_number: c_q, last: 1'b1,
							bad_cluster: 1'b0, truncated: 1'b0};
					end else begin
						result_q <= '{data_offset: pend_offs_q, byte_count: pend_cnt_q,
							cluster_number: pend_cl_q, last: 1'b1,
							bad_cluster: 1'b0, truncated: 1'b0};
					end
				end else if (k_q >= KW'(MAX_CHAIN)) begin
					result_q <= '{data_offset: pend_offs_q, byte_count: pend_cnt_q,
						cluster_number: pend_cl_q, last: 1'b1,
						bad_cluster: 1'b0, truncated: 1'b1};
				end else begin
					result_q <= '{data_offset: pend_offs_q, byte_count: pend_cnt_q,
						cluster_number: pend_cl_q, last: 1'b0,
						bad_cluster: 1'b0, truncated: 1'b0};
					if (c_q != CLUSTER_RSVD) begin
						pend_cnt_q <= cnt_sat;
						pend_cl_q  <= c_q;
						remain_q   <= clus_lt ? (remain_q - {11'd0, clus_q}) : 32'd0;
						prod_s1    <= prod_full;
						off_q      <= off;
					end
				end
			end
			ST_READ: begin
				pend_offs_q <= {3'd0, base_q} + prod_s1;
				c_q         <= next_c;
			end
			ST_BAD: begin
				result_q <= '{data_offset: 32'd0, byte_count: 20'd0,
					cluster_number: CLUSTER_RSVD, last: 1'b1,
					bad_cluster: 1'b1, truncated: 1'b0};
			end
			default: ;
		endcase
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// checks on the sequencer
	`FCW_ASSERT(a_res_from_walk, clk, arst_n, !result_valid || $past(busy), "result word outside a walk")
	`FCW_ASSERT(a_last_ends_walk, clk, arst_n, !(result_valid && result.last) || !busy, "last word but still busy")
	`FCW_ASSERT(a_more_keeps_busy, clk, arst_n, !(result_valid && !result.last) || busy, "walk ended without last")
	`FCW_ASSERT(a_trunc_is_last, clk, arst_n, !(result_valid && result.truncated) || result.last, "truncated word not last")
	`FCW_ASSERT(a_chain_limit, clk, arst_n, k_q <= KW'(MAX_CHAIN), "chain count past limit")
	`FCW_ASSERT_NEXT(a_walk_starts, clk, arst_n, start && !busy && (req.req_type == REQ_WALK), busy, "walk accepted but not busy")

endmodule
